>>> design/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
// No dependencies; every other design file except tcce_ifs imports this package.
`default_nettype none

package tcce_pkg;

  // command kinds on the input channel
  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_SAVE   = 3'd2;
  localparam logic [2:0] KIND_HOME   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;
  localparam logic [2:0] KIND_SCROLL = 3'd5;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE = 2'd2;

  localparam logic [7:0] RST_COLUMNS   = 8'd80;
  localparam logic [7:0] RST_ROWS      = 8'd25;
  localparam logic [7:0] RST_ATTRIBUTE = 8'd7;

  // command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_SCROLL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_PRINT,
    CMD_SET,
    CMD_SAVE,
    CMD_HOME,
    CMD_CLEAR,
    CMD_SCROLL
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [7:0]         ch;
    logic signed [15:0] col_req;
    logic signed [15:0] row_req;
  } item_t;

  typedef struct packed {
    logic [7:0] columns;
    logic [7:0] rows_count;
    logic [7:0] attribute;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/tcce_ifs.sv
// Channel interfaces of the text console cursor engine: command input and
// display operation output. Self-contained, no package needed.
`default_nettype none

interface tcce_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         char_code;
  logic signed [15:0] col_req;
  logic signed [15:0] row_req;

  modport source (output valid, kind, char_code, col_req, row_req, input ready);
  modport sink   (input valid, kind, char_code, col_req, row_req, output ready);
endinterface

interface tcce_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] cell_col;
  logic [7:0] cell_row;
  logic [7:0] cell_color;
  logic [7:0] glyph;
  logic       last;

  modport source (output valid, op, cell_col, cell_row, cell_color, glyph, last,
                  input ready);
  modport sink   (input valid, op, cell_col, cell_row, cell_color, glyph, last,
                  output ready);
endinterface

`default_nettype wire

>>> design/tcce_queue.sv
// Small command queue decoupling the front classifier from the back executor.
// Depends on tcce_pkg (item_t, QDEPTH, QAW).
`default_nettype none

module tcce_queue
  import tcce_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire item_t wr_item,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output item_t      rd_item
);

  item_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, rptr_r;
  logic [QAW:0]     count_r;
  logic             push, pop;

  assign wr_ready = (count_r != (QAW+1)'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QAW'(1);
      if (pop)  rptr_r <= rptr_r + QAW'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/tcce_front.sv
// Front end: accepts input transactions, decodes kind and control characters
// into a command class and pushes the command into the queue.
// Depends on tcce_pkg and tcce_ifs.
`default_nettype none

module tcce_front
  import tcce_pkg::*;
(
  tcce_in_if.sink    in_ch,
  output logic       q_valid,
  input  wire logic  q_ready,
  output item_t      q_item
);

  cmd_t cmd;

  always_comb begin
    unique case (in_ch.kind)
      KIND_WRITE: begin
        if (in_ch.char_code == CH_NEWLINE)        cmd = CMD_NEWLINE;
        else if (in_ch.char_code == CH_BACKSPACE) cmd = CMD_BACKSPACE;
        else                                      cmd = CMD_PRINT;
      end
      KIND_SET:    cmd = CMD_SET;
      KIND_SAVE:   cmd = CMD_SAVE;
      KIND_HOME:   cmd = CMD_HOME;
      KIND_CLEAR:  cmd = CMD_CLEAR;
      KIND_SCROLL: cmd = CMD_SCROLL;
      default:     cmd = CMD_NOP;
    endcase
  end

  // unused kinds are accepted and dropped here, never queued
  assign in_ch.ready    = q_ready;
  assign q_valid        = in_ch.valid && (cmd != CMD_NOP);
  assign q_item.cmd     = cmd;
  assign q_item.ch      = in_ch.char_code;
  assign q_item.col_req = in_ch.col_req;
  assign q_item.row_req = in_ch.row_req;

endmodule

`default_nettype wire

>>> design/tcce_back.sv
// Back end: executes queued commands against cursor and prompt state and
// sequences up to four display operations through a registered output.
// Depends on tcce_pkg and tcce_ifs.
`default_nettype none

module tcce_back
  import tcce_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire item_t q_item,
  tcce_out_if.source out_ch
);

  // cursor / prompt state
  logic [7:0] ccol_r, crow_r, pcol_r, prow_r;
  logic [7:0] ccol_nxt, crow_nxt, pcol_nxt, prow_nxt;

  // pending op slots: 0 put/clear, 1 scroll, 2 flush after scroll, 3 final flush
  logic [3:0] mask_r, mask_nxt, new_mask, mask_after, sel;
  op_t        s0_op_r, s0_op_nxt;
  logic [7:0] s0_col_r, s0_row_r, s0_glyph_r;
  logic [7:0] s0_col_nxt, s0_row_nxt, s0_glyph_nxt;

  // output register
  logic       ovalid_r, olast_r;
  op_t        oop_r;
  logic [7:0] ocol_r, orow_r, ocolor_r, oglyph_r;

  logic out_free, emit, pop;

  // execute helpers
  logic [7:0] cols, rows, cols_m1, rows_m1, prow_dec, bs_col;
  logic [8:0] row_inc;
  logic       grid_ok, at_bottom, bs_active, col_wrap, put_cur, put_bs;

  assign cols      = cfg.columns;
  assign rows      = cfg.rows_count;
  assign cols_m1   = cols - 8'd1;
  assign rows_m1   = rows - 8'd1;
  assign grid_ok   = (cols != 8'd0) && (rows != 8'd0);
  assign row_inc   = {1'b0, crow_r} + 9'd1;
  assign at_bottom = row_inc >= {1'b0, rows};
  assign prow_dec  = (prow_r != 8'd0) ? prow_r - 8'd1 : prow_r;
  assign bs_active = (crow_r > prow_r) || ((crow_r == prow_r) && (ccol_r > pcol_r));
  assign bs_col    = (ccol_r != 8'd0) ? ccol_r - 8'd1 : ccol_r;
  assign col_wrap  = ccol_r >= cols_m1;
  assign put_cur   = (ccol_r < cols) && (crow_r < rows);
  assign put_bs    = (bs_col < cols) && (crow_r < rows);

  always_comb begin
    ccol_nxt     = ccol_r;
    crow_nxt     = crow_r;
    pcol_nxt     = pcol_r;
    prow_nxt     = prow_r;
    new_mask     = 4'b0000;
    s0_op_nxt    = OP_PUT;
    s0_col_nxt   = ccol_r;
    s0_row_nxt   = crow_r;
    s0_glyph_nxt = q_item.ch;
    unique case (q_item.cmd)
      CMD_NEWLINE: begin
        if (grid_ok) begin
          ccol_nxt = 8'd0;
          if (at_bottom) begin
            crow_nxt = rows_m1;
            prow_nxt = prow_dec;
            new_mask = 4'b0110;
          end else begin
            crow_nxt = row_inc[7:0];
            new_mask = 4'b1000;
          end
        end
      end
      CMD_BACKSPACE: begin
        if (grid_ok && bs_active) begin
          ccol_nxt     = bs_col;
          s0_col_nxt   = bs_col;
          s0_glyph_nxt = 8'd0;
          new_mask     = {1'b1, 2'b00, put_bs};
        end
      end
      CMD_PRINT: begin
        if (grid_ok) begin
          if (col_wrap) begin
            ccol_nxt = 8'd0;
            if (at_bottom) begin
              crow_nxt = rows_m1;
              prow_nxt = prow_dec;
              new_mask = {3'b111, put_cur};
            end else begin
              crow_nxt = row_inc[7:0];
              new_mask = {3'b100, put_cur};
            end
          end else begin
            ccol_nxt = ccol_r + 8'd1;
            new_mask = {3'b100, put_cur};
          end
        end
      end
      CMD_SET: begin
        if (!grid_ok) begin
          ccol_nxt = 8'd0;
          crow_nxt = 8'd0;
        end else begin
          if (q_item.col_req < 16'sd0)                         ccol_nxt = 8'd0;
          else if (q_item.col_req > $signed({8'h00, cols_m1})) ccol_nxt = cols_m1;
          else                                                  ccol_nxt = q_item.col_req[7:0];
          if (q_item.row_req < 16'sd0)                         crow_nxt = 8'd0;
          else if (q_item.row_req > $signed({8'h00, rows_m1})) crow_nxt = rows_m1;
          else                                                  crow_nxt = q_item.row_req[7:0];
        end
      end
      CMD_SAVE: begin
        pcol_nxt = ccol_r;
        prow_nxt = crow_r;
      end
      CMD_HOME: begin
        ccol_nxt = 8'd0;
        crow_nxt = 8'd0;
        pcol_nxt = 8'd0;
        prow_nxt = 8'd0;
      end
      CMD_CLEAR: begin
        s0_op_nxt    = OP_CLEAR;
        s0_col_nxt   = 8'd0;
        s0_row_nxt   = 8'd0;
        s0_glyph_nxt = 8'd0;
        new_mask     = 4'b1001;
      end
      CMD_SCROLL: begin
        if (rows != 8'd0) crow_nxt = rows_m1;
        prow_nxt = prow_dec;
        new_mask = 4'b0110;
      end
      default: begin
      end
    endcase
  end

  // lowest pending slot goes out next
  always_comb begin
    priority if (mask_r[0]) sel = 4'b0001;
    else if (mask_r[1])     sel = 4'b0010;
    else if (mask_r[2])     sel = 4'b0100;
    else if (mask_r[3])     sel = 4'b1000;
    else                    sel = 4'b0000;
  end

  assign out_free   = !ovalid_r || out_ch.ready;
  assign emit       = (mask_r != 4'b0000) && out_free;
  assign mask_after = emit ? (mask_r & ~sel) : mask_r;
  // next command is executed as soon as the previous one has no op left to hand over
  assign q_ready    = (mask_after == 4'b0000);
  assign pop        = q_valid && q_ready;
  assign mask_nxt   = pop ? new_mask : mask_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccol_r   <= 8'd0;
      crow_r   <= 8'd0;
      pcol_r   <= 8'd0;
      prow_r   <= 8'd0;
      mask_r   <= 4'b0000;
      ovalid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (pop) begin
        ccol_r <= ccol_nxt;
        crow_r <= crow_nxt;
        pcol_r <= pcol_nxt;
        prow_r <= prow_nxt;
      end
      if (emit)          ovalid_r <= 1'b1;
      else if (out_free) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s0_op_r    <= s0_op_nxt;
      s0_col_r   <= s0_col_nxt;
      s0_row_r   <= s0_row_nxt;
      s0_glyph_r <= s0_glyph_nxt;
    end
    if (emit) begin
      olast_r <= (mask_r & ~sel) == 4'b0000;
      unique case (sel)
        4'b0001: begin
          oop_r    <= s0_op_r;
          ocol_r   <= s0_col_r;
          orow_r   <= s0_row_r;
          ocolor_r <= cfg.attribute;
          oglyph_r <= s0_glyph_r;
        end
        4'b0010: begin
          oop_r    <= OP_SCROLL;
          ocol_r   <= 8'd0;
          orow_r   <= 8'd0;
          ocolor_r <= cfg.attribute;
          oglyph_r <= 8'd0;
        end
        default: begin
          oop_r    <= OP_FLUSH;
          ocol_r   <= 8'd0;
          orow_r   <= 8'd0;
          ocolor_r <= 8'd0;
          oglyph_r <= 8'd0;
        end
      endcase
    end
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.op         = oop_r;
  assign out_ch.cell_col   = ocol_r;
  assign out_ch.cell_row   = orow_r;
  assign out_ch.cell_color = ocolor_r;
  assign out_ch.glyph      = oglyph_r;
  assign out_ch.last       = olast_r;

endmodule

`default_nettype wire

>>> design/text_console_cursor_engine_core.sv
// Top level of the text console cursor engine: configuration registers,
// front classifier, command queue and back executor.
// Depends on tcce_pkg, tcce_ifs, tcce_front, tcce_queue, tcce_back.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        kind, char_code, col_req, row_req
//   out_ch   out  valid/ready        op, cell_col, cell_row, cell_color, glyph, last
//   cfg_*    in   cfg_we, no ready   cfg_idx (2b), cfg_wdata (8b)
//
// Each command is executed once the previous one has handed its last op to
// the output register; its ops (0 to 4) then pass one at a time through the
// single output register, which holds each op until it is taken. Reset
// (rst_n low, synchronous) zeroes cursor and prompt, loads 80x25 grid and
// attribute 7, and empties the 4-entry queue.
// An output stall holds the current op; the queue keeps taking commands
// until it fills.
`default_nettype none

module text_console_cursor_engine_core
  import tcce_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [7:0]           cfg_wdata,
  tcce_in_if.sink                   in_ch,
  tcce_out_if.source                out_ch
);

  cfg_t  cfg_r;
  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  item_t fq_item, qb_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns    <= RST_COLUMNS;
      cfg_r.rows_count <= RST_ROWS;
      cfg_r.attribute  <= RST_ATTRIBUTE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_COLUMNS:   cfg_r.columns    <= cfg_wdata;
        CFG_ROWS:      cfg_r.rows_count <= cfg_wdata;
        CFG_ATTRIBUTE: cfg_r.attribute  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tcce_front u_front (
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  tcce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  tcce_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_item  (qb_item),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

>>> design/tcce_checker.sv
// Port-level checks on the display operation channel of the top level,
// attached by bind. Depends on tcce_pkg (op codes).
`default_nettype none

module tcce_checker
  import tcce_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_op,
  input wire logic [7:0] out_cell_col,
  input wire logic [7:0] out_cell_row,
  input wire logic [7:0] out_cell_color,
  input wire logic [7:0] out_glyph,
  input wire logic       out_last
);

  // nothing left over from before reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_op) && $stable(out_last)
      && $stable(out_cell_col) && $stable(out_cell_row) && $stable(out_glyph))
    else $error("stalled transaction changed");

  // put, scroll and clear are always followed by a flush of the same command
  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_op != OP_FLUSH) |-> !out_last)
    else $error("command ended without a flush");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_op == OP_FLUSH) |->
      (out_cell_col == 8'd0) && (out_cell_row == 8'd0)
      && (out_cell_color == 8'd0) && (out_glyph == 8'd0))
    else $error("flush carries cell data");

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_op         (out_ch.op),
  .out_cell_col   (out_ch.cell_col),
  .out_cell_row   (out_ch.cell_row),
  .out_cell_color (out_ch.cell_color),
  .out_glyph      (out_ch.glyph),
  .out_last       (out_ch.last)
);

`default_nettype wire
